// File: src/ascrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascrr_pkg
// Shared types and constants for the round-robin associative slot cache.
// ----------------------------------------------------------------------------
package ascrr_pkg;

  localparam int unsigned KEY_W      = 8;
  localparam int unsigned SLOT_IDX_W = 3;

  localparam logic [KEY_W-1:0] NO_CONTROL_KEY_RST = 8'hFF;

  typedef struct packed {
    logic [KEY_W-1:0] request_key;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_IDX_W-1:0] slot_index;
  } rsp_t;

  typedef logic [KEY_W-1:0] cfg_t;

endpackage
`default_nettype wire

// File: src/ascrr_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascrr_chan_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface ascrr_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/assoc_slot_cache_round_robin.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// assoc_slot_cache_round_robin
// Fully associative key store with round-robin slot allocation.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                    meaning
//  -------  ---  -------------------------  ---------------------------------
//  req_i    in   request_key[7:0]           key to look up / allocate
//  rsp_o    out  hit, slot_index[2:0]       slot holding the key
//  cfg_i    in   no_control_key[7:0]        key that always allocates
//
//  Pipeline: a request beat is captured in an input register; then the
//  parallel compare, victim advance and slot write happen together and the
//  response lands in the output register. One beat per cycle sustained
//  while the response side takes beats; throughput is set by the single
//  compare-and-update step on the flip-flop key store.
//  Reset: valid bits and victim pointer clear at once and the no-control key
//  returns to all ones; the key store itself is not reset (unwritten entries
//  are never matched).
//  Stalls: a held response blocks the lookup stage, which then backs up the
//  input register; req ready drops only when both are full.
//
module assoc_slot_cache_round_robin #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  ascrr_chan_if.sink         req_i,
  ascrr_chan_if.source       rsp_o,
  ascrr_chan_if.sink         cfg_i
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

  // Always-ready config; user must keep block idle when written, unenforced.
  logic [ascrr_pkg::KEY_W-1:0] nck_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nck_q <= ascrr_pkg::NO_CONTROL_KEY_RST;
    end else if (cfg_i.valid) begin
      nck_q <= cfg_i.payload;
    end
  end

  // Input register.
  logic                        in_valid_q;
  logic [ascrr_pkg::KEY_W-1:0] in_key_q;
  logic                        adv;       // lookup stage fires this cycle
  logic                        rsp_valid_q;
  ascrr_pkg::rsp_t             rsp_q;

  assign adv         = in_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_key_q <= req_i.payload.request_key;
    end
  end

  // Slot store: keys in flip-flops, valid bits reset.
  logic [ascrr_pkg::KEY_W-1:0] slot_keys_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]       slot_valid_q;
  logic [IDX_W-1:0]            victim_q;
  logic [IDX_W-1:0]            victim_d;

  // Parallel compare; the lowest matching slot wins (duplicates can appear
  // after the no-control key is changed).
  logic             lookup_hit;
  logic [IDX_W-1:0] hit_idx;
  logic             is_nck;

  always_comb begin
    is_nck     = (in_key_q == nck_q);
    lookup_hit = 1'b0;
    hit_idx    = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_valid_q[i] && (slot_keys_q[i] == in_key_q) && !is_nck) begin
        lookup_hit = 1'b1;
        hit_idx    = IDX_W'(i);
      end
    end
    victim_d = (victim_q == LAST_SLOT) ? '0 : victim_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      victim_q     <= '0;
      slot_valid_q <= '0;
    end else if (adv && !lookup_hit) begin
      victim_q               <= victim_d;
      slot_valid_q[victim_d] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && !lookup_hit) begin
      slot_keys_q[victim_d] <= in_key_q;
    end
  end

  // Response register; slot_index carries the low three bits of the slot.
  logic [IDX_W-1:0]   slot_sel;
  logic [IDX_W+2:0]   slot_ext;

  assign slot_sel = lookup_hit ? hit_idx : victim_d;
  assign slot_ext = {3'b000, slot_sel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (adv) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_q.hit        <= lookup_hit;
      rsp_q.slot_index <= slot_ext[ascrr_pkg::SLOT_IDX_W-1:0];
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // Assertions.
  // A freshly allocated slot is the new victim and is valid afterwards.
  a_alloc_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !lookup_hit |=> slot_valid_q[victim_q])
    else $error("allocated slot not marked valid");

  // The victim pointer moves only on an allocation.
  a_victim_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && !lookup_hit) |=> $stable(victim_q))
    else $error("victim pointer moved without allocation");

  // A blocked lookup stage keeps its beat.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_key_q))
    else $error("stalled request beat lost");

  // The no-control key never reports a hit.
  a_nck_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_nck |=> rsp_valid_q && !rsp_q.hit)
    else $error("no-control key returned a hit");

endmodule
`default_nettype wire

// File: sim/assoc_slot_cache_round_robin_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assoc_slot_cache_round_robin_chk
// Watches the request, response and config channels of the slot cache, keeps
// a mirror of its tag store and checks every response beat in order.
// ----------------------------------------------------------------------------
module assoc_slot_cache_round_robin_chk #(
  parameter int unsigned SLOTS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic            req_ready_i,
  input  ascrr_pkg::req_t req_i,
  input  logic            rsp_valid_i,
  input  logic            rsp_ready_i,
  input  ascrr_pkg::rsp_t rsp_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  ascrr_pkg::cfg_t cfg_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o
);

  logic [ascrr_pkg::KEY_W-1:0] tag_mirror [SLOTS];
  logic [SLOTS-1:0]            tag_live;
  int unsigned                 victim_slot;
  ascrr_pkg::cfg_t             alloc_key;
  ascrr_pkg::rsp_t             expected_slots [$];
  int unsigned                 rsp_beat_no = 0;
  int unsigned                 fails = 0;

  assign fail_count_o = fails;

  task automatic report_mismatch(input string what, input ascrr_pkg::rsp_t got,
                                 input ascrr_pkg::rsp_t want);
    $display("[%0t] chk: %s at rsp beat %0d: got hit=%0b slot=%0d, want hit=%0b slot=%0d",
             $time, what, rsp_beat_no, got.hit, got.slot_index, want.hit, want.slot_index);
    fails++;
  endtask

  // Lookup skipped for the alloc key; lowest matching live slot wins.
  function automatic ascrr_pkg::rsp_t lookup_or_allocate(
    input logic [ascrr_pkg::KEY_W-1:0] key
  );
    ascrr_pkg::rsp_t res;
    bit              found;
    res   = '0;
    found = 1'b0;
    if (key != alloc_key) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (!found && tag_live[s] && tag_mirror[s] == key) begin
          found          = 1'b1;
          res.hit        = 1'b1;
          res.slot_index = ascrr_pkg::SLOT_IDX_W'(s);
        end
      end
    end
    if (!found) begin
      // pointer advances before use
      victim_slot             = (victim_slot + 1 >= SLOTS) ? 0 : victim_slot + 1;
      tag_mirror[victim_slot] = key;
      tag_live[victim_slot]   = 1'b1;
      res.hit                 = 1'b0;
      res.slot_index          = ascrr_pkg::SLOT_IDX_W'(victim_slot);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ascrr_pkg::rsp_t want;
    if (!rst_ni) begin
      tag_live    = '0;
      victim_slot = 0;
      alloc_key   = ascrr_pkg::NO_CONTROL_KEY_RST;
      expected_slots.delete();
    end else begin
      // response first: it can never belong to a request taken this edge
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_slots.size() == 0) begin
          report_mismatch("unexpected beat", rsp_i, '0);
        end else begin
          want = expected_slots.pop_front();
          if (rsp_i.hit !== want.hit || rsp_i.slot_index !== want.slot_index) begin
            report_mismatch("mismatch", rsp_i, want);
          end
        end
        rsp_beat_no++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        alloc_key = cfg_i;
      end
      if (req_valid_i && req_ready_i) begin
        expected_slots.push_back(lookup_or_allocate(req_i.request_key));
      end
    end
    pending_o = expected_slots.size();
  end

endmodule

// File: sim/assoc_slot_cache_round_robin_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assoc_slot_cache_round_robin_tb
// Drives key requests and no-control key writes into the slot cache, with
// random gaps on both channels; a side checker predicts every response.
// ----------------------------------------------------------------------------
//
// Flow:
//   - reset, then a short directed run: first allocation lands in slot 1,
//     hit on a stored key, no-control key always allocating (even when a
//     live slot holds it), duplicate tags resolving to the lowest slot after
//     the no-control key moves, and a full wrap of the victim pointer.
//   - six random phases, each opened by a config write taken while the block
//     is drained. Keys mostly come from a small per-phase pool so that hits,
//     evictions and re-allocations all show up; the rest are the current
//     no-control key or fully random keys.
//   - the response side stalls on its own; once, after a few hundred request
//     beats, it holds ready low long enough for the request side to back up.
//
module assoc_slot_cache_round_robin_tb;

  localparam int unsigned SLOTS       = 8;
  localparam int unsigned POOL_SZ     = 10;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_BEATS = 140;
  localparam int unsigned DRAIN_CYC   = 6;    // pipeline is two deep
  localparam int unsigned SQUEEZE_AT  = 300;  // request beats before long hold
  localparam int unsigned SQUEEZE_LEN = 80;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned req_beats = 0;
  logic [ascrr_pkg::KEY_W-1:0] key_pool [POOL_SZ];

  ascrr_chan_if #(.payload_t(ascrr_pkg::req_t)) req_if ();
  ascrr_chan_if #(.payload_t(ascrr_pkg::rsp_t)) rsp_if ();
  ascrr_chan_if #(.payload_t(ascrr_pkg::cfg_t)) cfg_if ();

  assoc_slot_cache_round_robin #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  assoc_slot_cache_round_robin_chk #(
    .SLOTS(SLOTS)
  ) chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_if.valid),
    .req_ready_i (req_if.ready),
    .req_i       (req_if.payload),
    .rsp_valid_i (rsp_if.valid),
    .rsp_ready_i (rsp_if.ready),
    .rsp_i       (rsp_if.payload),
    .cfg_valid_i (cfg_if.valid),
    .cfg_ready_i (cfg_if.ready),
    .cfg_i       (cfg_if.payload),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("assoc_slot_cache_round_robin_tb: FAIL");
    $finish;
  end

  // Request beat counter; the response side uses it to time the long hold.
  always @(posedge clk) begin
    if (req_if.valid && req_if.ready) begin
      req_beats <= req_beats + 1;
    end
  end

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Called in the active region right after a posedge; returns at the edge
  // that takes the beat, so the next call can keep valid high with no gap.
  task automatic send_key(input logic [ascrr_pkg::KEY_W-1:0] key, input int unsigned gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid               <= 1'b1;
    req_if.payload.request_key <= key;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Stop offering, wait until every predicted response has been seen, then
  // let the pipeline settle before touching the config register. The count
  // is sampled at the falling edge so the beat just taken is included.
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_alloc_key(input ascrr_pkg::cfg_t key);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= key;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [ascrr_pkg::KEY_W-1:0] pick_key(input ascrr_pkg::cfg_t alloc_key);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return key_pool[$urandom_range(0, POOL_SZ - 1)];
    if (r < 70) return alloc_key;
    return ascrr_pkg::KEY_W'($urandom_range(0, 255));
  endfunction

  // Response side: random stalls, calm windows, and one long hold-off.
  initial begin
    int unsigned stall_left;
    int unsigned calm_left;
    bit          squeezed;
    stall_left = 0;
    calm_left  = 0;
    squeezed   = 1'b0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!squeezed && req_beats >= SQUEEZE_AT) begin
        squeezed   = 1'b1;
        stall_left = SQUEEZE_LEN;
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 199) == 0) begin
          calm_left = 150;
        end else begin
          stall_left = gap_len();
        end
      end
    end
  end

  // Request side and config writes.
  initial begin
    ascrr_pkg::cfg_t             cur_alloc_key;
    ascrr_pkg::cfg_t             phase_key;
    logic [ascrr_pkg::KEY_W-1:0] base;
    bit                          calm;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    rst_n          <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset no-control key (all ones).
    send_key(8'h00, gap_len());   // miss: first alloc goes to slot 1
    send_key(8'h00, gap_len());   // hit slot 1
    send_key(8'hFF, gap_len());   // no-control: slot 2
    send_key(8'hFF, 0);           // no-control again despite live tag: slot 3

    // Move the no-control key to zero: the two all-ones tags now collide.
    drain();
    write_alloc_key(8'h00);
    cur_alloc_key = 8'h00;
    send_key(8'hFF, gap_len());   // hit, lowest of two matching slots
    send_key(8'h00, gap_len());   // no-control, slot 1 holds it but still allocs
    // one-hot keys: eight allocations wrap the victim pointer past slot 7
    for (int b = 0; b < ascrr_pkg::KEY_W; b++) begin
      send_key(ascrr_pkg::KEY_W'(1) << b, gap_len());
    end
    send_key(8'h80, 0);           // most recent tag: hit
    send_key(8'hFF, gap_len());   // all-ones tags evicted by now: miss
    send_key(8'h7F, 0);
    send_key(8'hFE, 0);

    // Random phases; each starts with a config write on an idle block.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0, PHASES - 1: begin
          phase_key = 8'hFF;
        end
        2: begin
          phase_key = 8'h00;
        end
        default: begin
          phase_key = ascrr_pkg::KEY_W'($urandom_range(0, 255));
        end
      endcase
      // Old no-control key goes in the pool: slots that took it while it
      // was the no-control key now give duplicate tags.
      key_pool[0] = cur_alloc_key;
      base = ascrr_pkg::KEY_W'($urandom_range(0, 255));
      for (int i = 1; i < POOL_SZ; i++) begin
        key_pool[i] = phase[0] ? ascrr_pkg::KEY_W'($urandom_range(0, 255))
                               : base + ascrr_pkg::KEY_W'($urandom_range(0, 15));
      end
      drain();
      write_alloc_key(phase_key);
      cur_alloc_key = phase_key;
      calm = (phase == 3);
      for (int unsigned n = 0; n < PHASE_BEATS; n++) begin
        send_key(pick_key(cur_alloc_key), calm ? 0 : gap_len());
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("assoc_slot_cache_round_robin_tb: PASS");
    end else begin
      $display("assoc_slot_cache_round_robin_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: assoc_slot_cache_round_robin.f
src/ascrr_pkg.sv
src/ascrr_chan_if.sv
src/assoc_slot_cache_round_robin.sv
sim/assoc_slot_cache_round_robin_chk.sv
sim/assoc_slot_cache_round_robin_tb.sv
